### rtl/was_pkg.sv
// shared types and codes of the worker admission scheduler
package was_pkg;

	localparam int ACT_W  = 4;
	localparam int TID_W  = 4;
	localparam int STS_W  = 3;
	localparam int TST_W  = 3;
	localparam int CNT_W  = 5;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int INIT_W = 5;

	// request actions
	localparam logic [ACT_W-1:0] ACT_ATTACH      = 4'd0;
	localparam logic [ACT_W-1:0] ACT_DETACH      = 4'd1;
	localparam logic [ACT_W-1:0] ACT_YIELD       = 4'd2;
	localparam logic [ACT_W-1:0] ACT_BLOCK_START = 4'd3;
	localparam logic [ACT_W-1:0] ACT_BLOCK_END   = 4'd4;
	localparam logic [ACT_W-1:0] ACT_SET_HIGH    = 4'd5;
	localparam logic [ACT_W-1:0] ACT_SET_NORMAL  = 4'd6;
	localparam logic [ACT_W-1:0] ACT_RAISE       = 4'd7;
	localparam logic [ACT_W-1:0] ACT_LOWER       = 4'd8;

	// result status
	localparam logic [STS_W-1:0] STS_OK           = 3'd0;
	localparam logic [STS_W-1:0] STS_ALREADY_ATT  = 3'd1;
	localparam logic [STS_W-1:0] STS_NOT_ATT      = 3'd2;
	localparam logic [STS_W-1:0] STS_NOT_WORK     = 3'd3;
	localparam logic [STS_W-1:0] STS_ALREADY_HIGH = 3'd4;
	localparam logic [STS_W-1:0] STS_NOT_HIGH     = 3'd5;
	localparam logic [STS_W-1:0] STS_BREACH       = 3'd6;

	// per-slot thread state
	localparam logic [TST_W-1:0] ST_UNATT = 3'd0;
	localparam logic [TST_W-1:0] ST_WORK  = 3'd1;
	localparam logic [TST_W-1:0] ST_WAIT  = 3'd2;
	localparam logic [TST_W-1:0] ST_BLOCK = 3'd3;
	localparam logic [TST_W-1:0] ST_READY = 3'd4;

	// register index, taken from paddr bit 2
	localparam logic REG_IDX_INIT = 1'b0;

	localparam logic [INIT_W-1:0] INIT_RESET = 5'd4;

	typedef struct packed {
		logic load;
		logic exec;
	} was_cmd_t;

endpackage

### rtl/was_req_if.sv
// request channel: action and thread slot
interface was_req_if import was_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [TID_W-1:0] thread_id;

	modport source(output valid, action, thread_id, input ready);
	modport sink(input valid, action, thread_id, output ready);
endinterface

### rtl/was_rsp_if.sv
// result channel: status and scheduler snapshot
interface was_rsp_if import was_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [STS_W-1:0] status;
	logic [TST_W-1:0] caller_state;
	logic             woken_valid;
	logic [TID_W-1:0] woken_thread;
	logic             limit_lowered;
	logic [CNT_W-1:0] working_count;
	logic [CNT_W-1:0] max_working;

	modport source(output valid, status, caller_state, woken_valid, woken_thread,
		limit_lowered, working_count, max_working, input ready);
	modport sink(input valid, status, caller_state, woken_valid, woken_thread,
		limit_lowered, working_count, max_working, output ready);
endinterface

### rtl/worker_admission_scheduler.sv
// top level of the worker admission scheduler
//
// usage
// - req carries one request item (action, thread_id); it is taken when
//   valid and ready are both high
// - rsp carries one result item per request; it is taken when valid and
//   ready are both high, and holds its payload while the receiver stalls
// - the register port holds initial_max_working at byte address 0; a
//   write also reloads the live limit, clamped to 1..THREADS
// sequencing
// - a request is latched when taken, executes when the result slot is
//   free and registers its result; the next is taken only after that, so
//   the registered waiting-slot search refreshes from new slot states
// - a stalled result keeps the next request waiting in the execute
//   stage; a new request is taken as soon as that one has executed
// reset
// - arst_n clears every slot to unattached, empties the ready queue and
//   loads the live limit from the register reset value
module worker_admission_scheduler import was_pkg::*; #(
	parameter int THREADS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	was_req_if.sink           req,
	was_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	was_cmd_t cmd;

	// register port never waits
	assign pready = 1'b1;

	// sequencer: take an item, execute when the result slot is free
	was_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// slot state, ready queue, depth store and result registers
	was_dpath #(.THREADS(THREADS)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_action    (req.action),
		.req_thread_id (req.thread_id),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.status        (rsp.status),
		.caller_state  (rsp.caller_state),
		.woken_valid   (rsp.woken_valid),
		.woken_thread  (rsp.woken_thread),
		.limit_lowered (rsp.limit_lowered),
		.working_count (rsp.working_count),
		.max_working   (rsp.max_working)
	);

endmodule

### rtl/was_ctrl.sv
// request sequencer: accept, execute, result handoff
module was_ctrl import was_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output was_cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_nx;
	logic ovld_q;
	logic out_free;

	assign out_free  = !ovld_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = ovld_q;
	assign cmd.load  = req_ready && req_valid;
	assign cmd.exec  = (state_q == S_EXEC) && out_free;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.load) state_nx = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.exec) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.exec) ovld_q <= 1'b1;
			else if (rsp_ready) ovld_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_exec_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp_valid)
		else $error("result not presented after execute");
	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_EXEC) && !req_ready)
		else $error("accepted item not held for execute");
	a_stall_holds_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && ovld_q && !rsp_ready) |=> (state_q == S_EXEC))
		else $error("item executed over a waiting result");
`endif

endmodule

### rtl/was_wfind.sv
// lowest-index waiting slot search, registered per group of eight
module was_wfind #(
	parameter int THREADS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [THREADS-1:0]         wait_mask,
	output logic                       found,
	output logic [$clog2(THREADS)-1:0] idx
);

	localparam int SW = $clog2(THREADS);
	localparam int NG = (THREADS + 7) / 8;

	logic [NG*8-1:0] mask_pad;
	logic [NG-1:0]   gany_c;
	logic [2:0]      gidx_c [NG];
	logic [NG-1:0]   any_s1;
	logic [2:0]      bidx_s1 [NG];

	assign mask_pad = (NG*8)'(wait_mask);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			gany_c[g] = |mask_pad[g*8 +: 8];
			gidx_c[g] = 3'd0;
			for (int b = 7; b >= 0; b--) begin
				if (mask_pad[g*8 + b]) gidx_c[g] = 3'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_s1 <= '0;
		end else begin
			any_s1 <= gany_c;
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) bidx_s1[g] <= gidx_c[g];
	end

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				found = 1'b1;
				idx   = SW'(g * 8 + int'(bidx_s1[g]));
			end
		end
	end

endmodule

### rtl/was_dpath.sv
// scheduler state, ready queue, depth store and request execution
module was_dpath import was_pkg::*; #(
	parameter int THREADS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  was_cmd_t          cmd,
	input  logic [ACT_W-1:0]  req_action,
	input  logic [TID_W-1:0]  req_thread_id,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic [STS_W-1:0]  status,
	output logic [TST_W-1:0]  caller_state,
	output logic              woken_valid,
	output logic [TID_W-1:0]  woken_thread,
	output logic              limit_lowered,
	output logic [CNT_W-1:0]  working_count,
	output logic [CNT_W-1:0]  max_working
);

	localparam int SW = $clog2(THREADS);
	localparam int CW = $clog2(THREADS + 1);
	localparam int XW = SW + TID_W;

	// slot state
	logic [TST_W-1:0]  state_q [THREADS];
	logic [THREADS-1:0] hp_q;
	logic [THREADS-1:0] dep_vld_q;
	logic [THREADS-1:0] wait_mask;
	logic [7:0]         dep_mem [THREADS];
	logic [SW-1:0]      fifo_mem [THREADS];
	logic [SW-1:0]      head_q;
	logic [CW-1:0]      rcnt_q;
	logic [CW-1:0]      lim_q;
	logic [CW-1:0]      wcnt_q;
	logic [INIT_W-1:0]  init_q;

	// item latched at accept
	logic [ACT_W-1:0] act_q;
	logic [SW-1:0]    slot_q;
	logic             in_rng_q;
	logic [7:0]       dep_rd_q;
	logic             dep_rd_vld_q;
	logic [SW-1:0]    fifo_rd_q;

	logic [XW-1:0] tid_wide;
	logic [SW-1:0] slot_l;
	logic          rng_l;

	logic          wf_found;
	logic [SW-1:0] wf_idx;

	logic             cfg_wr;
	logic [TST_W-1:0] st_c;
	logic [TST_W-1:0] nt_c;
	logic             hp_c;
	logic             att_c;
	logic             chk_c;
	logic [STS_W-1:0] err_c;
	logic [7:0]       dep_c;
	logic [STS_W-1:0] sts_c;
	logic             t_wr_c;
	logic             do_act_c;
	logic             hp_wr_c;
	logic             hp_val_c;
	logic             dep_wr_c;
	logic [7:0]       dep_val_c;
	logic             enq_c;
	logic             lim_inc_c;
	logic             lim_dec_c;
	logic             lowered_c;
	logic             fifo_ne;
	logic             wv_c;
	logic             pop_c;
	logic [SW-1:0]    act_slot;
	logic [CW-1:0]    lim_m1;
	logic [CW-1:0]    wcnt_m1;
	logic [1:0]       up_c;
	logic             dn_c;
	logic [CW-1:0]    wcnt_nx;
	logic [CW-1:0]    lim_nx;
	logic [SW+1:0]    tail_sum;
	logic [SW-1:0]    tail_c;
	logic [SW-1:0]    head_nx;

	// result registers
	logic [STS_W-1:0] status_q;
	logic [TST_W-1:0] cs_q;
	logic             wv_q;
	logic [TID_W-1:0] woken_q;
	logic             lowered_q;
	logic [CNT_W-1:0] wcount_q;
	logic [CNT_W-1:0] maxw_q;

	function automatic logic [CW-1:0] clamp_lim(input logic [INIT_W-1:0] v);
		logic [6:0] w;
		w = 7'(v);
		if (w == 7'd0) return CW'(1);
		if (w > 7'(THREADS)) return CW'(THREADS);
		return CW'(w);
	endfunction

	assign tid_wide = {{SW{1'b0}}, req_thread_id};
	assign rng_l    = tid_wide < XW'(THREADS);
	assign slot_l   = tid_wide[SW-1:0];

	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_INIT);
	assign prdata = (paddr[2] == REG_IDX_INIT) ? DATA_W'(init_q) : '0;

	always_comb begin
		for (int i = 0; i < THREADS; i++) wait_mask[i] = (state_q[i] == ST_WAIT);
	end

	was_wfind #(.THREADS(THREADS)) u_wfind (
		.clk       (clk),
		.arst_n    (arst_n),
		.wait_mask (wait_mask),
		.found     (wf_found),
		.idx       (wf_idx)
	);

	assign fifo_ne  = (rcnt_q != '0);
	assign act_slot = fifo_ne ? fifo_rd_q : wf_idx;
	assign lim_m1   = lim_q - CW'(1);
	assign wcnt_m1  = wcnt_q - CW'(1);

	// request execution
	always_comb begin
		st_c      = in_rng_q ? state_q[slot_q] : ST_UNATT;
		hp_c      = in_rng_q && hp_q[slot_q];
		dep_c     = dep_rd_vld_q ? dep_rd_q : 8'd0;
		att_c     = (st_c != ST_UNATT);
		chk_c     = att_c && (st_c == ST_WORK);
		err_c     = att_c ? STS_NOT_WORK : STS_NOT_ATT;
		sts_c     = STS_OK;
		nt_c      = st_c;
		t_wr_c    = 1'b0;
		do_act_c  = 1'b0;
		hp_wr_c   = 1'b0;
		hp_val_c  = 1'b0;
		dep_wr_c  = 1'b0;
		dep_val_c = 8'd0;
		enq_c     = 1'b0;
		lim_inc_c = 1'b0;
		lim_dec_c = 1'b0;
		lowered_c = 1'b0;
		if (!in_rng_q) begin
			sts_c = STS_NOT_ATT;
		end else begin
			unique case (act_q)
				ACT_ATTACH: begin
					if (att_c) begin
						sts_c = STS_ALREADY_ATT;
					end else begin
						t_wr_c = 1'b1;
						nt_c   = (wcnt_q < lim_q) ? ST_WORK : ST_WAIT;
					end
				end
				ACT_DETACH: begin
					if (!chk_c) begin
						sts_c = err_c;
					end else begin
						t_wr_c   = 1'b1;
						nt_c     = ST_UNATT;
						dep_wr_c = 1'b1;
						hp_wr_c  = 1'b1;
						// too many still working: no one is let in
						if (wcnt_m1 >= lim_q) sts_c = STS_BREACH;
						else do_act_c = 1'b1;
					end
				end
				ACT_YIELD: begin
					if (!chk_c) begin
						sts_c = err_c;
					end else if (fifo_ne) begin
						do_act_c = 1'b1;
						t_wr_c   = 1'b1;
						nt_c     = ST_WAIT;
					end
				end
				ACT_BLOCK_START: begin
					if (!att_c) begin
						sts_c = STS_NOT_ATT;
					end else if (hp_c) begin
						sts_c = STS_OK;
					end else if (st_c != ST_WORK && st_c != ST_BLOCK) begin
						sts_c = STS_NOT_WORK;
					end else begin
						dep_wr_c  = 1'b1;
						dep_val_c = (dep_c != 8'hFF) ? dep_c + 8'd1 : dep_c;
						// only the outermost block gives up the slot
						if (dep_val_c == 8'd1) begin
							t_wr_c   = 1'b1;
							nt_c     = ST_BLOCK;
							do_act_c = 1'b1;
						end
					end
				end
				ACT_BLOCK_END: begin
					if (!att_c) begin
						sts_c = STS_NOT_ATT;
					end else if (!hp_c && st_c == ST_BLOCK) begin
						dep_wr_c = 1'b1;
						t_wr_c   = 1'b1;
						if (wcnt_q == lim_q && rcnt_q < CW'(THREADS)) begin
							enq_c = 1'b1;
							nt_c  = ST_READY;
						end else begin
							nt_c = ST_WORK;
						end
					end
				end
				ACT_SET_HIGH, ACT_SET_NORMAL: begin
					if (!chk_c) begin
						sts_c = err_c;
					end else if (act_q == ACT_SET_HIGH) begin
						if (hp_c) begin
							sts_c = STS_ALREADY_HIGH;
						end else begin
							hp_wr_c  = 1'b1;
							hp_val_c = 1'b1;
						end
					end else begin
						if (!hp_c) sts_c = STS_NOT_HIGH;
						else hp_wr_c = 1'b1;
					end
				end
				ACT_RAISE: begin
					if (!chk_c) begin
						sts_c = err_c;
					end else begin
						do_act_c  = 1'b1;
						lim_inc_c = (lim_q < CW'(THREADS));
					end
				end
				ACT_LOWER: begin
					if (!chk_c) begin
						sts_c = err_c;
					end else if (lim_q > CW'(1)) begin
						lim_dec_c = 1'b1;
						lowered_c = 1'b1;
						if (wcnt_q > lim_m1) begin
							t_wr_c = 1'b1;
							nt_c   = ST_WAIT;
						end
					end
				end
				default: sts_c = STS_OK;
			endcase
		end
		wv_c  = do_act_c && (fifo_ne || wf_found);
		pop_c = wv_c && fifo_ne;
		up_c  = {1'b0, wv_c} + {1'b0, (t_wr_c && nt_c == ST_WORK && st_c != ST_WORK)};
		dn_c  = t_wr_c && (st_c == ST_WORK) && (nt_c != ST_WORK);
	end

	assign wcnt_nx  = wcnt_q + CW'(up_c) - CW'(dn_c);
	assign lim_nx   = lim_q + CW'(lim_inc_c) - CW'(lim_dec_c);
	assign tail_sum = (SW+2)'(head_q) + (SW+2)'(rcnt_q);
	assign tail_c   = (tail_sum >= (SW+2)'(THREADS)) ?
		SW'(tail_sum - (SW+2)'(THREADS)) : SW'(tail_sum);
	assign head_nx  = (head_q == SW'(THREADS - 1)) ? '0 : head_q + SW'(1);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) state_q[i] <= ST_UNATT;
			hp_q      <= '0;
			dep_vld_q <= '0;
			head_q    <= '0;
			rcnt_q    <= '0;
			wcnt_q    <= '0;
			lim_q     <= clamp_lim(INIT_RESET);
			init_q    <= INIT_RESET;
		end else begin
			if (cfg_wr) begin
				init_q <= pwdata[INIT_W-1:0];
				lim_q  <= clamp_lim(pwdata[INIT_W-1:0]);
			end else if (cmd.exec) begin
				lim_q <= lim_nx;
			end
			if (cmd.exec) begin
				// woken slot is never the caller
				if (wv_c) state_q[act_slot] <= ST_WORK;
				if (t_wr_c) state_q[slot_q] <= nt_c;
				if (hp_wr_c) hp_q[slot_q] <= hp_val_c;
				if (dep_wr_c) dep_vld_q[slot_q] <= 1'b1;
				if (pop_c) head_q <= head_nx;
				if (enq_c) rcnt_q <= rcnt_q + CW'(1);
				else if (pop_c) rcnt_q <= rcnt_q - CW'(1);
				wcnt_q <= wcnt_nx;
			end
		end
	end

	// blocking depth store
	always_ff @(posedge clk) begin
		if (cmd.exec && dep_wr_c) dep_mem[slot_q] <= dep_val_c;
		if (cmd.load && rng_l) dep_rd_q <= dep_mem[slot_l];
	end

	// ready queue store
	always_ff @(posedge clk) begin
		if (cmd.exec && enq_c) fifo_mem[tail_c] <= slot_q;
		if (cmd.load) fifo_rd_q <= fifo_mem[head_q];
	end

	// item and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q        <= req_action;
			slot_q       <= slot_l;
			in_rng_q     <= rng_l;
			dep_rd_vld_q <= rng_l && dep_vld_q[slot_l];
		end
		if (cmd.exec) begin
			status_q  <= sts_c;
			cs_q      <= nt_c;
			wv_q      <= wv_c;
			woken_q   <= wv_c ? TID_W'(act_slot) : '0;
			lowered_q <= lowered_c;
			wcount_q  <= CNT_W'(wcnt_nx);
			maxw_q    <= CNT_W'(lim_nx);
		end
	end

	assign status        = status_q;
	assign caller_state  = cs_q;
	assign woken_valid   = wv_q;
	assign woken_thread  = woken_q;
	assign limit_lowered = lowered_q;
	assign working_count = wcount_q;
	assign max_working   = maxw_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (wcnt_q <= CW'(THREADS)) && (rcnt_q <= CW'(THREADS)))
		else $error("working or ready count beyond slot count");
	a_limit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.exec && !cfg_wr) |=> $stable(lim_q))
		else $error("limit moved without a request or register write");
`endif

endmodule

### dv/testbench.sv
// self-checking testbench of the worker admission scheduler
`timescale 1ns / 100ps

module testbench;
	import was_pkg::*;

	localparam int NSLOTS    = 16;
	localparam int DEPTH_MAX = 255;
	localparam int SETTLE    = 8;
	localparam logic [ADDR_W-1:0] LIMIT_REG_ADDR = {REG_IDX_INIT, 2'b00};
	// actions the block does not define, passed through with status ok
	localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 4'd9;
	localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 4'd15;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [TST_W-1:0] caller_state;
		logic             woken_valid;
		logic [TID_W-1:0] woken_thread;
		logic             limit_lowered;
		logic [CNT_W-1:0] working_count;
		logic [CNT_W-1:0] max_working;
	} sched_outcome_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	was_req_if req_ch ();
	was_rsp_if rsp_ch ();

	worker_admission_scheduler #(.THREADS(NSLOTS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the scheduler state, advanced once per accepted item
	logic [TST_W-1:0]  slot_state [NSLOTS];
	logic [7:0]        slot_depth [NSLOTS];
	logic              slot_high  [NSLOTS];
	logic [TID_W-1:0]  ready_order[$];
	logic [INIT_W-1:0] limit_reg;
	logic [CNT_W-1:0]  limit_now;
	logic [CNT_W-1:0]  working_now;

	// outcomes still owed by the block, oldest first
	sched_outcome_t pending_outcomes[$];

	int items_sent;
	int outcomes_checked;
	int limit_writes;
	int mismatch_count;
	int stall_hold;

	function automatic logic [CNT_W-1:0] clamp_limit(input logic [INIT_W-1:0] v);
		if (v == '0)
			return CNT_W'(1);
		if (v > NSLOTS)
			return CNT_W'(NSLOTS);
		return CNT_W'(v);
	endfunction

	function automatic logic [CNT_W-1:0] count_working();
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < NSLOTS; i++)
			if (slot_state[i] == ST_WORK)
				n++;
		return n;
	endfunction

	// ready queue head first, else the lowest waiting slot
	function automatic logic wake_one(output logic [TID_W-1:0] who);
		who = '0;
		if (ready_order.size() != 0) begin
			who = ready_order.pop_front();
			slot_state[who] = ST_WORK;
			return 1'b1;
		end
		for (int i = 0; i < NSLOTS; i++) begin
			if (slot_state[i] == ST_WAIT) begin
				who = TID_W'(i);
				slot_state[i] = ST_WORK;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// applies one request to the shadow state and returns what the block must report
	function automatic sched_outcome_t schedule_request(input logic [ACT_W-1:0] act,
		input logic [TID_W-1:0] tid);
		sched_outcome_t   r;
		logic [TST_W-1:0] st;
		logic             att;
		logic [TID_W-1:0] who;
		r   = '0;
		who = '0;
		st  = slot_state[tid];
		att = (st != ST_UNATT);
		case (act)
			ACT_ATTACH: begin
				if (att)
					r.status = STS_ALREADY_ATT;
				else
					slot_state[tid] = (working_now < limit_now) ? ST_WORK : ST_WAIT;
			end
			ACT_DETACH: begin
				if (!att)
					r.status = STS_NOT_ATT;
				else if (st != ST_WORK)
					r.status = STS_NOT_WORK;
				else begin
					slot_state[tid] = ST_UNATT;
					slot_depth[tid] = '0;
					slot_high[tid]  = 1'b0;
					// still too many working after removal: nobody gets woken
					if (count_working() >= limit_now)
						r.status = STS_BREACH;
					else
						r.woken_valid = wake_one(who);
				end
			end
			ACT_YIELD: begin
				if (!att)
					r.status = STS_NOT_ATT;
				else if (st != ST_WORK)
					r.status = STS_NOT_WORK;
				else if (ready_order.size() != 0) begin
					r.woken_valid = wake_one(who);
					slot_state[tid] = ST_WAIT;
				end
			end
			ACT_BLOCK_START: begin
				if (!att)
					r.status = STS_NOT_ATT;
				else if (slot_high[tid]) begin
					// high-priority slots never block
				end else if (st != ST_WORK && st != ST_BLOCK)
					r.status = STS_NOT_WORK;
				else begin
					if (slot_depth[tid] != DEPTH_MAX)
						slot_depth[tid]++;
					if (slot_depth[tid] == 8'd1) begin
						slot_state[tid] = ST_BLOCK;
						r.woken_valid = wake_one(who);
					end
				end
			end
			ACT_BLOCK_END: begin
				if (!att)
					r.status = STS_NOT_ATT;
				else if (!slot_high[tid] && st == ST_BLOCK) begin
					slot_depth[tid] = '0;
					if (working_now == limit_now && ready_order.size() < NSLOTS) begin
						ready_order.push_back(tid);
						slot_state[tid] = ST_READY;
					end else
						slot_state[tid] = ST_WORK;
				end
			end
			ACT_SET_HIGH, ACT_SET_NORMAL: begin
				if (!att)
					r.status = STS_NOT_ATT;
				else if (st != ST_WORK)
					r.status = STS_NOT_WORK;
				else if (act == ACT_SET_HIGH) begin
					if (slot_high[tid])
						r.status = STS_ALREADY_HIGH;
					else
						slot_high[tid] = 1'b1;
				end else begin
					if (!slot_high[tid])
						r.status = STS_NOT_HIGH;
					else
						slot_high[tid] = 1'b0;
				end
			end
			ACT_RAISE: begin
				if (!att)
					r.status = STS_NOT_ATT;
				else if (st != ST_WORK)
					r.status = STS_NOT_WORK;
				else begin
					r.woken_valid = wake_one(who);
					if (limit_now < NSLOTS)
						limit_now++;
				end
			end
			ACT_LOWER: begin
				if (!att)
					r.status = STS_NOT_ATT;
				else if (st != ST_WORK)
					r.status = STS_NOT_WORK;
				else if (limit_now > 1) begin
					limit_now--;
					r.limit_lowered = 1'b1;
					if (working_now > limit_now)
						slot_state[tid] = ST_WAIT;
				end
			end
			default: begin
				// spare action codes change nothing
			end
		endcase
		working_now     = count_working();
		r.caller_state  = slot_state[tid];
		r.woken_thread  = r.woken_valid ? who : '0;
		r.working_count = working_now;
		r.max_working   = limit_now;
		return r;
	endfunction

	// a random slot currently in the given state, or -1
	function automatic int find_slot(input logic [TST_W-1:0] want);
		int hits[$];
		for (int i = 0; i < NSLOTS; i++)
			if (slot_state[i] == want)
				hits.push_back(i);
		if (hits.size() == 0)
			return -1;
		return hits[$urandom_range(0, hits.size() - 1)];
	endfunction

	// mostly requests that make sense for the current slot states, some noise
	function automatic void pick_request(output logic [ACT_W-1:0] act,
		output logic [TID_W-1:0] tid);
		int               roll;
		int               slot;
		logic [TST_W-1:0] want;
		roll = $urandom_range(0, 99);
		if (roll < 16)
			act = ACT_ATTACH;
		else if (roll < 28)
			act = ACT_DETACH;
		else if (roll < 38)
			act = ACT_YIELD;
		else if (roll < 54)
			act = ACT_BLOCK_START;
		else if (roll < 70)
			act = ACT_BLOCK_END;
		else if (roll < 76)
			act = ACT_SET_HIGH;
		else if (roll < 82)
			act = ACT_SET_NORMAL;
		else if (roll < 89)
			act = ACT_RAISE;
		else if (roll < 96)
			act = ACT_LOWER;
		else
			act = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
		if (act == ACT_ATTACH)
			want = ST_UNATT;
		else if (act == ACT_BLOCK_END)
			want = ST_BLOCK;
		else
			want = ST_WORK;
		slot = find_slot(want);
		if (slot >= 0 && $urandom_range(0, 4) != 0)
			tid = TID_W'(slot);
		else
			tid = TID_W'($urandom_range(0, NSLOTS - 1));
	endfunction

	// offer one item and hold it until taken; called just after a rising edge
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [TID_W-1:0] tid);
		req_ch.valid     <= 1'b1;
		req_ch.action    <= act;
		req_ch.thread_id <= tid;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_outcomes.push_back(schedule_request(act, tid));
		items_sent++;
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles == 0)
			return;
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stop offering and let every owed item come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_outcomes.size() != 0);
	endtask

	// one apb transfer: setup, then access until pready
	task automatic limit_reg_access(input logic wr, input logic [DATA_W-1:0] wdata,
		output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= LIMIT_REG_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdata = prdata;
			@(posedge clk);
		end while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_limit_reg();
		logic [DATA_W-1:0] rd;
		limit_reg_access(1'b0, '0, rd);
		if (rd !== DATA_W'(limit_reg)) begin
			$error("initial_max_working: expected %0d, got %0d", limit_reg, rd);
			mismatch_count++;
		end
	endtask

	// only called with the block idle
	task automatic write_limit(input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] rd;
		limit_reg_access(1'b1, value, rd);
		limit_reg = value[INIT_W-1:0];
		limit_now = clamp_limit(limit_reg);
		limit_writes++;
		check_limit_reg();
	endtask

	task automatic send_random_bursts(input int count);
		int left;
		int burst;
		logic [ACT_W-1:0] act;
		logic [TID_W-1:0] tid;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && left > 0; i++) begin
				pick_request(act, tid);
				send_request(act, tid);
				left--;
			end
			// some bursts run straight into the next one
			idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
		end
	endtask

	// error codes, attach over the limit, ready queue, yield, raise and lower
	task automatic test_directed();
		send_request(ACT_DETACH, 4'd0);
		for (int i = 0; i < 4; i++)
			send_request(ACT_ATTACH, TID_W'(i));
		send_request(ACT_ATTACH, 4'd4);
		send_request(ACT_ATTACH, 4'd0);
		send_request(ACT_YIELD, 4'd0);
		send_request(ACT_DETACH, 4'd4);
		send_request(ACT_SET_HIGH, 4'd1);
		send_request(ACT_SET_HIGH, 4'd1);
		// high priority: blocking requests are no-ops
		send_request(ACT_BLOCK_START, 4'd1);
		send_request(ACT_BLOCK_END, 4'd1);
		send_request(ACT_SET_NORMAL, 4'd1);
		send_request(ACT_SET_NORMAL, 4'd1);
		// block wakes the waiting slot, nested block, then finish with limit full
		send_request(ACT_BLOCK_START, 4'd2);
		send_request(ACT_BLOCK_START, 4'd2);
		send_request(ACT_BLOCK_END, 4'd2);
		idle_sender(3);
		send_request(ACT_YIELD, 4'd0);
		send_request(ACT_BLOCK_START, 4'd0);
		send_request(ACT_RAISE, 4'd1);
		send_request(ACT_LOWER, 4'd1);
		send_request(ACT_SPARE_FIRST, 4'd15);
		send_request(ACT_SPARE_LAST, 4'd3);
		send_request(ACT_BLOCK_START, 4'd5);
		drain_results();
	endtask

	// limit register extremes: clamp, detach breach, floor and ceiling
	task automatic test_limit_edges();
		int slot;
		check_limit_reg();
		// upper data bits are ignored, low bits give a limit of one
		write_limit({{(DATA_W - INIT_W){1'b1}}, 5'd1});
		slot = find_slot(ST_WORK);
		if (slot >= 0)
			send_request(ACT_DETACH, TID_W'(slot));
		slot = find_slot(ST_WORK);
		if (slot >= 0)
			send_request(ACT_LOWER, TID_W'(slot));
		drain_results();
		write_limit(32'd31);
		slot = find_slot(ST_WORK);
		if (slot >= 0) begin
			send_request(ACT_RAISE, TID_W'(slot));
			send_request(ACT_RAISE, TID_W'(slot));
		end
		drain_results();
		write_limit({{(DATA_W - INIT_W){1'b1}}, 5'd0});
		slot = find_slot(ST_UNATT);
		if (slot >= 0)
			send_request(ACT_ATTACH, TID_W'(slot));
		drain_results();
	endtask

	// blocking depth runs into its ceiling, then one finish clears it
	task automatic test_depth_saturation();
		int slot;
		write_limit(32'd16);
		slot = find_slot(ST_WORK);
		if (slot < 0) begin
			slot = find_slot(ST_UNATT);
			if (slot >= 0)
				send_request(ACT_ATTACH, TID_W'(slot));
		end
		if (slot >= 0 && slot_state[TID_W'(slot)] == ST_WORK) begin
			if (slot_high[TID_W'(slot)])
				send_request(ACT_SET_NORMAL, TID_W'(slot));
			repeat (DEPTH_MAX + 3) send_request(ACT_BLOCK_START, TID_W'(slot));
			send_request(ACT_BLOCK_END, TID_W'(slot));
		end
		drain_results();
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		logic [ACT_W-1:0] act;
		logic [TID_W-1:0] tid;
		write_limit(32'd8);
		stall_hold = 250;
		repeat (40) begin
			pick_request(act, tid);
			send_request(act, tid);
		end
		drain_results();
	endtask

	// random traffic over several limit settings, extremes included
	task automatic test_random_phases();
		logic [DATA_W-1:0] setting;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: setting = 32'd16;
				1: setting = 32'd1;
				2: setting = 32'd4;
				3: setting = 32'd31;
				4: setting = $urandom;
				default: setting = $urandom_range(2, 15);
			endcase
			write_limit(setting);
			send_random_bursts(150);
			drain_results();
		end
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// result checker: every taken item against the oldest owed outcome
	always @(posedge clk) begin
		sched_outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result item with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("status", 8'(want.status), 8'(rsp_ch.status));
				check_field("caller_state", 8'(want.caller_state),
					8'(rsp_ch.caller_state));
				check_field("woken_valid", 8'(want.woken_valid),
					8'(rsp_ch.woken_valid));
				check_field("woken_thread", 8'(want.woken_thread),
					8'(rsp_ch.woken_thread));
				check_field("limit_lowered", 8'(want.limit_lowered),
					8'(rsp_ch.limit_lowered));
				check_field("working_count", 8'(want.working_count),
					8'(rsp_ch.working_count));
				check_field("max_working", 8'(want.max_working),
					8'(rsp_ch.max_working));
				outcomes_checked++;
			end
		end
	end

	// receiver stall pattern: modes of random length, plus a requested long hold
	initial begin
		int hold_left;
		int mode;
		int mode_left;
		int tick;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		tick = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_hold != 0) begin
				hold_left = stall_hold;
				stall_hold = 0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: rsp_ch.ready <= (tick % 5 != 0);
				endcase
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.action    = '0;
		req_ch.thread_id = '0;
		items_sent       = 0;
		outcomes_checked = 0;
		limit_writes     = 0;
		mismatch_count   = 0;
		stall_hold       = 0;
		// shadow state matches the block after reset
		for (int i = 0; i < NSLOTS; i++) begin
			slot_state[i] = ST_UNATT;
			slot_depth[i] = '0;
			slot_high[i]  = 1'b0;
		end
		ready_order.delete();
		limit_reg   = INIT_RESET;
		limit_now   = clamp_limit(INIT_RESET);
		working_now = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_limit_edges();
		test_depth_saturation();
		test_backpressure();
		test_random_phases();

		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("run: %0d requests sent, %0d results checked, %0d limit register writes",
			items_sent, outcomes_checked, limit_writes);
		$display("covered every action, error codes, ready queue, depth ceiling, backpressure");
		if (mismatch_count == 0 && pending_outcomes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/was_pkg.sv
rtl/was_req_if.sv
rtl/was_rsp_if.sv
rtl/was_ctrl.sv
rtl/was_wfind.sv
rtl/was_dpath.sv
rtl/worker_admission_scheduler.sv
dv/testbench.sv
